FILE: hw/rtl/wsdfr_pkg.sv
// Package for the WebSocket frame deframer with payload unmasking.
// Holds widths, header constants, the parse phase type and the result item struct.
// No dependencies.
package wsdfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 4;
  localparam int unsigned LenW    = 64;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned HdrCntW = 4;

  // Length codes in the second header byte
  localparam logic [6:0] LenMaxShort = 7'd125;
  localparam logic [6:0] LenCode16   = 7'd126;

  // Header bytes still due in each header phase
  localparam logic [HdrCntW-1:0] HdrCnt16  = 4'd2;
  localparam logic [HdrCntW-1:0] HdrCnt64  = 4'd8;
  localparam logic [HdrCntW-1:0] HdrCntKey = 4'd4;

  typedef enum logic [2:0] {
    PH_BYTE0,
    PH_BYTE1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD
  } phase_e;

  // One result item
  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic [OpW-1:0]   opcode;
    logic             fin;
    logic             masked;
    logic [LenW-1:0]  length;
    logic             empty;
    logic             last;
  } result_t;

endpackage

FILE: hw/rtl/wsdfr_in_stage.sv
// Input register of the deframer: holds one stream byte until the parser takes it.
// Depends on wsdfr_pkg.
module wsdfr_in_stage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [wsdfr_pkg::ByteW-1:0] stream_byte_i,
  input  logic                    take_i,
  output logic                    held_valid_o,
  output logic [wsdfr_pkg::ByteW-1:0] held_byte_o
);
  import wsdfr_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  // Accept while empty or while the held item leaves this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load the payload on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= stream_byte_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

endmodule

FILE: hw/rtl/wsdfr_parser.sv
// Frame parser: header state machine, length and key capture, payload unmasking.
// Depends on wsdfr_pkg.
module wsdfr_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [wsdfr_pkg::ByteW-1:0] byte_i,
  output logic                        emit_o,
  output wsdfr_pkg::result_t          result_o
);
  import wsdfr_pkg::*;

  phase_e             phase_q, phase_d;
  logic [HdrCntW-1:0] cnt_q, cnt_d;
  logic               fin_q, fin_d;
  logic [OpW-1:0]     opcode_q, opcode_d;
  logic               mask_q, mask_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [LenW-1:0]    length_q, length_d;
  logic [LenW-1:0]    remain_q, remain_d;
  logic [1:0]         kidx_q, kidx_d;
  logic [6:0]         code;
  logic [ByteW-1:0]   key_byte;

  assign code = byte_i[6:0];

  // Next state
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    fin_d    = fin_q;
    opcode_d = opcode_q;
    mask_d   = mask_q;
    key_d    = key_q;
    length_d = length_q;
    remain_d = remain_q;
    kidx_d   = kidx_q;
    unique case (phase_q)
      PH_BYTE1: begin
        mask_d = byte_i[7];
        if (code <= LenMaxShort) begin
          length_d = {{(LenW-7){1'b0}}, code};
          if (byte_i[7]) begin
            key_d   = '0;
            cnt_d   = HdrCntKey;
            phase_d = PH_MASK;
          end else if (code == 7'd0) begin
            phase_d = PH_BYTE0;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end else begin
          length_d = '0;
          cnt_d    = (code == LenCode16) ? HdrCnt16 : HdrCnt64;
          phase_d  = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        length_d = {length_q[LenW-ByteW-1:0], byte_i};
        cnt_d    = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          if (mask_q) begin
            key_d   = '0;
            cnt_d   = HdrCntKey;
            phase_d = PH_MASK;
          end else if (length_d == '0) begin
            phase_d = PH_BYTE0;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_MASK: begin
        key_d = {key_q[KeyW-ByteW-1:0], byte_i};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          phase_d = (length_q == '0) ? PH_BYTE0 : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        remain_d = remain_q - 64'd1;
        kidx_d   = kidx_q + 2'd1;
        if (remain_q == 64'd1) begin
          phase_d = PH_BYTE0;
        end
      end
      default: begin
        fin_d    = byte_i[7];
        opcode_d = byte_i[OpW-1:0];
        phase_d  = PH_BYTE1;
      end
    endcase
    // Arm the payload counters on entry to the payload phase
    if (phase_d == PH_PAYLOAD && phase_q != PH_PAYLOAD) begin
      remain_d = length_d;
      kidx_d   = 2'd0;
    end
  end

  // Pick the key byte for this payload byte, first received first
  always_comb begin
    unique case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Outputs: results carry the state as it stands after this byte
  always_comb begin
    emit_o                = 1'b0;
    result_o.payload_byte = '0;
    result_o.opcode       = opcode_q;
    result_o.fin          = fin_q;
    result_o.masked       = mask_d;
    result_o.length       = length_d;
    result_o.empty        = 1'b0;
    result_o.last         = 1'b0;
    unique case (phase_q)
      PH_BYTE1: begin
        emit_o = (code == 7'd0) && !byte_i[7];
      end
      PH_EXTLEN: begin
        emit_o = (cnt_q == 4'd1) && !mask_q && (length_d == '0);
      end
      PH_MASK: begin
        emit_o = (cnt_q == 4'd1) && (length_q == '0);
      end
      PH_PAYLOAD: begin
        emit_o                = 1'b1;
        result_o.payload_byte = byte_i ^ (mask_q ? key_byte : 8'h00);
        result_o.last         = (remain_q == 64'd1);
      end
      default: begin
        emit_o = 1'b0;
      end
    endcase
    // A header that completes a zero-length frame gives the empty result
    if (emit_o && phase_q != PH_PAYLOAD) begin
      result_o.empty = 1'b1;
      result_o.last  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_BYTE0;
      cnt_q    <= '0;
      fin_q    <= 1'b0;
      opcode_q <= '0;
      mask_q   <= 1'b0;
      key_q    <= '0;
      length_q <= '0;
      remain_q <= '0;
      kidx_q   <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      fin_q    <= fin_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      key_q    <= key_d;
      length_q <= length_d;
      remain_q <= remain_d;
      kidx_q   <= kidx_d;
    end
  end

endmodule

FILE: hw/rtl/wsdfr_out_stage.sv
// Result register of the deframer: holds one result item until the sink takes it.
// Depends on wsdfr_pkg.
module wsdfr_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  wsdfr_pkg::result_t result_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wsdfr_pkg::result_t result_o
);
  import wsdfr_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Slot is free when empty or drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

FILE: hw/rtl/websocket_frame_deframer_unmask_unit.sv
// Top level of the WebSocket frame deframer with payload unmasking.
// Depends on wsdfr_pkg, wsdfr_in_stage, wsdfr_parser and wsdfr_out_stage.

// The block takes one stream byte per cycle and splits the stream into frames.
// Header bytes (two fixed bytes, an optional 2- or 8-byte big-endian length and
// an optional 4-byte mask key) give no result; each payload byte gives one
// result, in a masked frame XORed with the key byte of its position modulo 4,
// with frame_end on the last one. A frame of length zero gives a single result
// with empty_frame set on its last header byte. A byte goes from the input
// register through the parser into the result register: its result is loaded
// when the byte leaves the input register and is shown on the outputs from then
// on. One byte is taken every cycle while the result register drains; the only
// stall is a full result register that the sink does not take while the held
// byte would produce a result.
module websocket_frame_deframer_unmask_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wsdfr_pkg::ByteW-1:0]  stream_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [wsdfr_pkg::ByteW-1:0]  payload_byte_o,
  output logic [wsdfr_pkg::OpW-1:0]    frame_opcode_o,
  output logic                         final_fragment_o,
  output logic                         was_masked_o,
  output logic [wsdfr_pkg::LenW-1:0]   frame_length_o,
  output logic                         empty_frame_o,
  output logic                         frame_end_o
);
  import wsdfr_pkg::*;

  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             emit;
  logic             out_free;
  logic             fire;
  result_t          result;
  result_t          out_res;

  // Advance the held byte unless its result has nowhere to go
  assign fire = held_valid && (!emit || out_free);

  wsdfr_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .stream_byte_i(stream_byte_i),
    .take_i       (fire),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte)
  );

  wsdfr_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (held_byte),
    .emit_o  (emit),
    .result_o(result)
  );

  wsdfr_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire && emit),
    .result_i   (result),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_o   (out_res)
  );

  assign payload_byte_o   = out_res.payload_byte;
  assign frame_opcode_o   = out_res.opcode;
  assign final_fragment_o = out_res.fin;
  assign was_masked_o     = out_res.masked;
  assign frame_length_o   = out_res.length;
  assign empty_frame_o    = out_res.empty;
  assign frame_end_o      = out_res.last;

  // An empty-frame result ends its frame, carries no byte and a zero length
  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_frame_o |->
      frame_end_o && (payload_byte_o == 8'h00) && (frame_length_o == 64'd0))
    else $error("empty-frame result malformed");

  // A payload result belongs to a frame of nonzero length
  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !empty_frame_o |-> frame_length_o != 64'd0)
    else $error("payload result with zero frame length");

  // Input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> held_valid && emit && out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

  // A result loaded into a free slot is shown in the next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && emit |=> out_valid_o)
    else $error("result lost on load");

endmodule

FILE: tb/tb_websocket_frame_deframer_unmask_unit.sv
// Self-checking testbench for websocket_frame_deframer_unmask_unit.
// Sends WebSocket frames byte by byte and checks each result against a byte-level predictor.
// Depends on wsdfr_pkg and the deframer RTL.
module tb_websocket_frame_deframer_unmask_unit;
  import wsdfr_pkg::*;

  localparam logic [6:0] LenCode64  = 7'd127;
  localparam int         QuietLimit = 3000;
  localparam int         DrainCycles = 20;
  localparam int         HoldCycles = 300;
  localparam int         NumDirRows = 29;

  // One row of the directed table: a stream byte and, where typed in, its result
  typedef struct {
    logic [ByteW-1:0] b;
    bit               typed;
    result_t          r;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] stream_byte = '0;
  logic             out_valid_o;
  logic             out_ready = 1'b0;
  logic [ByteW-1:0] payload_byte_o;
  logic [OpW-1:0]   frame_opcode_o;
  logic             final_fragment_o;
  logic             was_masked_o;
  logic [LenW-1:0]  frame_length_o;
  logic             empty_frame_o;
  logic             frame_end_o;

  // Predicted parser state
  phase_e             ph = PH_BYTE0;
  logic [HdrCntW-1:0] hdr_left = '0;
  logic               cur_fin = 1'b0;
  logic [OpW-1:0]     cur_op = '0;
  logic               cur_masked = 1'b0;
  logic [KeyW-1:0]    cur_key = '0;
  logic [LenW-1:0]    cur_len = '0;
  logic [LenW-1:0]    bytes_done = '0;

  result_t payload_q[$];
  row_t    dir_rows [NumDirRows];
  int      n_mismatch = 0;
  int      n_accepted = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;
  bit      pressure_go = 1'b0;
  bit      pressure_done = 1'b0;

  websocket_frame_deframer_unmask_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .stream_byte_i    (stream_byte),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .payload_byte_o   (payload_byte_o),
    .frame_opcode_o   (frame_opcode_o),
    .final_fragment_o (final_fragment_o),
    .was_masked_o     (was_masked_o),
    .frame_length_o   (frame_length_o),
    .empty_frame_o    (empty_frame_o),
    .frame_end_o      (frame_end_o)
  );

  // Toggle the clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic row_t mk_row(logic [ByteW-1:0] b, bit typed = 1'b0, result_t r = '0);
    row_t row;
    row.b = b;
    row.typed = typed;
    row.r = r;
    return row;
  endfunction

  task automatic flag_mismatch(string what, logic [LenW-1:0] got, logic [LenW-1:0] want);
    $display("ERROR @%0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
    n_mismatch++;
  endtask

  // Length and key known: emit the empty-frame item or enter the payload
  task automatic payload_start(output bit gives, output result_t r);
    gives = 1'b0;
    r = '0;
    if (cur_len == '0) begin
      gives = 1'b1;
      r = '{payload_byte: '0, opcode: cur_op, fin: cur_fin, masked: cur_masked,
            length: cur_len, empty: 1'b1, last: 1'b1};
      ph = PH_BYTE0;
    end else begin
      bytes_done = '0;
      ph = PH_PAYLOAD;
    end
  endtask

  // Length known: collect the key first if the frame is masked
  task automatic length_ready(output bit gives, output result_t r);
    gives = 1'b0;
    r = '0;
    if (cur_masked) begin
      cur_key = '0;
      hdr_left = HdrCntKey;
      ph = PH_MASK;
    end else begin
      payload_start(gives, r);
    end
  endtask

  // Advance the predicted parser by one stream byte
  task automatic predict_byte(input logic [ByteW-1:0] b, output bit gives, output result_t r);
    int          k;
    logic [7:0]  key_b;
    logic        last;
    gives = 1'b0;
    r = '0;
    case (ph)
      PH_BYTE1: begin
        cur_masked = b[7];
        cur_len = '0;
        if (b[6:0] <= LenMaxShort) begin
          cur_len = LenW'(b[6:0]);
          length_ready(gives, r);
        end else begin
          hdr_left = (b[6:0] == LenCode16) ? HdrCnt16 : HdrCnt64;
          ph = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        cur_len = {cur_len[LenW-9:0], b};
        hdr_left = hdr_left - 1'b1;
        if (hdr_left == '0) length_ready(gives, r);
      end
      PH_MASK: begin
        cur_key = {cur_key[KeyW-9:0], b};
        hdr_left = hdr_left - 1'b1;
        if (hdr_left == '0) payload_start(gives, r);
      end
      PH_PAYLOAD: begin
        k = int'(bytes_done[1:0]);
        key_b = cur_masked ? cur_key[8*(3-k) +: 8] : 8'h00;
        bytes_done = bytes_done + 1'b1;
        last = (bytes_done == cur_len);
        gives = 1'b1;
        r = '{payload_byte: b ^ key_b, opcode: cur_op, fin: cur_fin, masked: cur_masked,
              length: cur_len, empty: 1'b0, last: last};
        if (last) ph = PH_BYTE0;
      end
      default: begin
        cur_fin = b[7];
        cur_op = b[3:0];
        ph = PH_BYTE1;
      end
    endcase
  endtask

  // Offer one item, hold it until accepted, then queue its expected result
  task automatic send_byte(input row_t row);
    bit      gives;
    result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    stream_byte = row.b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(row.b, gives, r);
    if (row.typed) payload_q.push_back(row.r);
    else if (gives) payload_q.push_back(r);
    n_accepted++;
  endtask

  // Send a whole frame; n_pay may be short of len to leave a frame open
  task automatic send_frame(input logic [7:0] b0, input bit masked, input logic [6:0] code,
                            input logic [LenW-1:0] len, input logic [KeyW-1:0] key,
                            input int n_pay);
    send_byte(mk_row(b0));
    send_byte(mk_row({masked, code}));
    if (code == LenCode16) begin
      send_byte(mk_row(len[15:8]));
      send_byte(mk_row(len[7:0]));
    end else if (code == LenCode64) begin
      for (int i = 7; i >= 0; i--) send_byte(mk_row(len[8*i +: 8]));
    end
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(mk_row(key[8*i +: 8]));
    end
    for (int i = 0; i < n_pay; i++) send_byte(mk_row(8'($urandom_range(255))));
  endtask

  // Drive out_ready: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (pressure_go && !pressure_done) begin
      hold_left = HoldCycles;
      pressure_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t e;
    if (rst_ni && out_valid_o && out_ready) begin
      if (payload_q.size() == 0) begin
        flag_mismatch("result with nothing expected, payload_byte", payload_byte_o, '0);
      end else begin
        e = payload_q.pop_front();
        if (payload_byte_o !== e.payload_byte)
          flag_mismatch("payload_byte", payload_byte_o, e.payload_byte);
        if (frame_opcode_o !== e.opcode)
          flag_mismatch("frame_opcode", frame_opcode_o, e.opcode);
        if (final_fragment_o !== e.fin)
          flag_mismatch("final_fragment", final_fragment_o, e.fin);
        if (was_masked_o !== e.masked)
          flag_mismatch("was_masked", was_masked_o, e.masked);
        if (frame_length_o !== e.length)
          flag_mismatch("frame_length", frame_length_o, e.length);
        if (empty_frame_o !== e.empty)
          flag_mismatch("empty_frame", empty_frame_o, e.empty);
        if (frame_end_o !== e.last)
          flag_mismatch("frame_end", frame_end_o, e.last);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int              frame_no;
    int              pick;
    logic [7:0]      b0;
    bit              masked;
    logic [6:0]      code;
    logic [LenW-1:0] len;
    logic [KeyW-1:0] key;

    // Directed table: empty frame, unmasked extremes, masked non-minimal 16-bit length,
    // masked 64-bit zero length with reserved opcode and RSV bits set
    dir_rows = '{
      mk_row(8'h81),
      mk_row(8'h00, 1'b1, '{8'h00, 4'h1, 1'b1, 1'b0, 64'd0, 1'b1, 1'b1}),
      mk_row(8'h02), mk_row(8'h02),
      mk_row(8'h00, 1'b1, '{8'h00, 4'h2, 1'b0, 1'b0, 64'd2, 1'b0, 1'b0}),
      mk_row(8'hFF, 1'b1, '{8'hFF, 4'h2, 1'b0, 1'b0, 64'd2, 1'b0, 1'b1}),
      mk_row(8'h89), mk_row(8'hFE), mk_row(8'h00), mk_row(8'h01),
      mk_row(8'hA5), mk_row(8'h5A), mk_row(8'hFF), mk_row(8'h00), mk_row(8'h0F),
      mk_row(8'h7F), mk_row(8'hFF),
      mk_row(8'h00), mk_row(8'h00), mk_row(8'h00), mk_row(8'h00),
      mk_row(8'h00), mk_row(8'h00), mk_row(8'h00), mk_row(8'h00),
      mk_row(8'hC3), mk_row(8'h3C), mk_row(8'h96),
      mk_row(8'h69, 1'b1, '{8'h00, 4'hF, 1'b0, 1'b1, 64'd0, 1'b1, 1'b1})
    };

    // Hold reset, then release it at a falling clock edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i]);

    // Random frames, idling pattern changing every eight frames
    frame_no = 0;
    while (n_accepted < 750) begin
      case ((frame_no / 8) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      b0 = 8'($urandom_range(255));
      masked = 1'($urandom_range(1));
      key = $urandom;
      pick = $urandom_range(99);
      if (frame_no == 12) begin
        // Long payload against a held-off receiver: fill the block
        idle_pct = 0;
        pressure_go = 1'b1;
        code = 7'd100;
        len = 64'd100;
      end else if (pick < 8) begin
        code = 7'd0;
        len = '0;
      end else if (pick < 65) begin
        code = 7'($urandom_range(8, 1));
        len = LenW'(code);
      end else if (pick < 75) begin
        code = 7'($urandom_range(125, 9));
        len = LenW'(code);
      end else if (pick < 87) begin
        code = LenCode16;
        len = LenW'($urandom_range(40));
      end else begin
        code = LenCode64;
        len = LenW'($urandom_range(20));
      end
      send_frame(b0, masked, code, len, key, int'(len));
      frame_no++;
    end

    // Leave a frame open whose 64-bit length has every bit set
    idle_pct = 0;
    stall_pct = 0;
    send_frame(8'($urandom_range(255)), 1'b1, LenCode64, '1, $urandom, 6);

    @(negedge clk_i);
    in_valid = 1'b0;
    while (payload_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
